@@ src/psarw_pkg.sv @@
// Shared types, constants and status codes of the anti-replay window unit.
package psarw_pkg;
    localparam int SOURCES   = 16;
    localparam int SRC_W     = 4;
    localparam int WINDOW    = 32;
    localparam int MAP_W     = WINDOW + 1;
    localparam int KIDX_W    = 6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNCHECKED = 3'd1;
    localparam logic [2:0] ST_BAD_EPOCH = 3'd2;
    localparam logic [2:0] ST_STALE     = 3'd3;
    localparam logic [2:0] ST_FLOOR     = 3'd4;
    localparam logic [2:0] ST_REPLAY    = 3'd5;
    localparam logic [2:0] ST_WINDOW    = 3'd6;

    typedef struct packed {
        logic              unchecked;
        logic              bad_epoch;
        logic [SRC_W-1:0]  src;
        logic [63:0]       epoch;
        logic [63:0]       tail;
        logic [63:0]       seq;
    } t_claim;

    typedef struct packed {
        logic [63:0]       epoch;
        logic [63:0]       tail;
        logic [63:0]       high;
        logic [MAP_W-1:0]  map;
    } t_entry;
endpackage

@@ src/per_source_anti_replay_window_unit.sv @@
// Top level of the per-source anti-replay window unit.
// Input channel: i_in_valid / o_in_ready move one claim beat (version, source
// index, boot epoch, boot tail, sequence number). Output channel:
// o_out_valid / i_out_ready move one result beat (accepted, status,
// state_changed) per claim, in claim order.
// i_cfg_we with i_cfg_data writes the guarded version; write only when idle.
// A two-deep queue parts the front end from the table back end, so claims
// are taken while a result waits.
// Each claim passes through the back end as a registered table read, then
// compare, update and result load; the single-port table read-modify-write
// keeps the back end from taking a new claim until the current one is done.
// If the receiver stalls, the result register holds, the back end waits in
// its update step and the queue fills; o_in_ready drops when it is full.
// Reset (synchronous, active low) sets the guarded version to 3, marks all
// sixteen source entries empty and flushes queue and result register.
module per_source_anti_replay_window_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_version,
    input  logic [3:0]  i_source_index,
    input  logic [63:0] i_boot_epoch_value,
    input  logic [63:0] i_boot_tail,
    input  logic [63:0] i_seq_number,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_accepted,
    output logic [2:0]  o_status,
    output logic        o_state_changed
);
    psarw_pkg::t_claim f_claim, q_claim;
    logic              push, q_full, q_valid, pop;

    psarw_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_version          (i_version),
        .i_source_index     (i_source_index),
        .i_boot_epoch_value (i_boot_epoch_value),
        .i_boot_tail        (i_boot_tail),
        .i_seq_number       (i_seq_number),
        .i_q_full           (q_full),
        .o_push             (push),
        .o_claim            (f_claim)
    );

    psarw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_claim (f_claim),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_claim (q_claim)
    );

    psarw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_claim         (q_claim),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_accepted      (o_accepted),
        .o_status        (o_status),
        .o_state_changed (o_state_changed)
    );
endmodule

@@ src/psarw_front.sv @@
// Front end: version register, beat acceptance and early classification.
module psarw_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [7:0]                 i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_version,
    input  logic [psarw_pkg::SRC_W-1:0] i_source_index,
    input  logic [63:0]                i_boot_epoch_value,
    input  logic [63:0]                i_boot_tail,
    input  logic [63:0]                i_seq_number,
    input  logic                       i_q_full,
    output logic                       o_push,
    output psarw_pkg::t_claim          o_claim
);
    logic [7:0] r_guarded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guarded <= 8'd3;
        end else if (i_cfg_we) begin
            r_guarded <= i_cfg_data;
        end
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_claim.unchecked = (i_version != r_guarded);
        o_claim.bad_epoch = (i_boot_epoch_value == 64'd0);
        o_claim.src       = i_source_index;
        o_claim.epoch     = i_boot_epoch_value;
        o_claim.tail      = i_boot_tail;
        o_claim.seq       = i_seq_number;
    end
endmodule

@@ src/psarw_queue.sv @@
// Two-deep claim queue between front and back ends.
module psarw_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  psarw_pkg::t_claim i_claim,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output psarw_pkg::t_claim o_claim
);
    psarw_pkg::t_claim r_slot [2];
    logic              r_wp, n_wp, r_rp, n_rp;
    logic [1:0]        r_cnt, n_cnt;

    always_comb begin
        n_wp  = i_push ? ~r_wp : r_wp;
        n_rp  = i_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_claim;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_claim = r_slot[r_rp];
endmodule

@@ src/psarw_back.sv @@
// Back end: source table read-modify-write and result register.
module psarw_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  psarw_pkg::t_claim i_claim,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_accepted,
    output logic [2:0]        o_status,
    output logic              o_state_changed
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    psarw_pkg::t_entry         mem [psarw_pkg::SOURCES];
    logic [psarw_pkg::SOURCES-1:0] r_vbits;
    logic                      r_state;
    psarw_pkg::t_claim         r_claim;
    psarw_pkg::t_entry         r_rd;
    logic                      r_hit_valid;
    logic                      r_out_valid;
    logic                      r_acc, r_chg;
    logic [2:0]                r_st;

    logic                      done, wr_en;
    logic                      n_acc, n_chg;
    logic [2:0]                n_st;
    psarw_pkg::t_entry         n_ent;
    logic [63:0]               k_back, k_fwd;
    logic [psarw_pkg::MAP_W-1:0] map_new;
    localparam logic [psarw_pkg::MAP_W-1:0] ONE_M = {{(psarw_pkg::MAP_W-1){1'b0}}, 1'b1};
    localparam logic [63:0] WIN64 = 64'(psarw_pkg::WINDOW);

    assign o_pop = (r_state == S_IDLE) && i_q_valid;
    assign done  = (r_state == S_EVAL) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_acc   = 1'b0;
        n_chg   = 1'b0;
        n_st    = psarw_pkg::ST_OK;
        wr_en   = 1'b0;
        n_ent   = r_rd;
        k_back  = r_rd.high - r_claim.seq;
        k_fwd   = r_claim.seq - r_rd.high;
        map_new = r_rd.map;
        if (r_claim.unchecked) begin
            n_acc = 1'b1;
            n_st  = psarw_pkg::ST_UNCHECKED;
        end else if (r_claim.bad_epoch) begin
            n_st = psarw_pkg::ST_BAD_EPOCH;
        end else if (!r_hit_valid || r_rd.epoch != r_claim.epoch
                     || r_rd.tail != r_claim.tail) begin
            if (r_hit_valid && r_claim.epoch <= r_rd.epoch) begin
                n_st = psarw_pkg::ST_STALE;
            end else begin
                n_acc       = 1'b1;
                n_chg       = 1'b1;
                wr_en       = 1'b1;
                n_ent.epoch = r_claim.epoch;
                n_ent.tail  = r_claim.tail;
                n_ent.high  = r_claim.seq;
                n_ent.map   = ONE_M;
            end
        end else if (r_claim.seq == 64'd0) begin
            n_st = psarw_pkg::ST_FLOOR;
        end else if (r_claim.seq <= r_rd.high && k_back <= WIN64
                     && r_rd.map[k_back[psarw_pkg::KIDX_W-1:0]]) begin
            n_st = psarw_pkg::ST_REPLAY;
        end else if (r_rd.high > WIN64 && r_claim.seq <= r_rd.high - WIN64) begin
            n_st = psarw_pkg::ST_WINDOW;
        end else begin
            n_acc = 1'b1;
            wr_en = 1'b1;
            if (r_claim.seq > r_rd.high) begin
                n_chg = 1'b1;
                if (k_fwd > WIN64) begin
                    map_new = ONE_M;
                end else begin
                    map_new = (r_rd.map << k_fwd[psarw_pkg::KIDX_W-1:0]) | ONE_M;
                end
                n_ent.high = r_claim.seq;
            end else begin
                map_new[k_back[psarw_pkg::KIDX_W-1:0]] = 1'b1;
            end
            if (n_ent.high > WIN64) begin
                map_new[psarw_pkg::MAP_W-1] = 1'b0;
            end
            n_ent.map = map_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vbits     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (done && wr_en) begin
                r_vbits[r_claim.src] <= 1'b1;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_claim     <= i_claim;
            r_rd        <= mem[i_claim.src];
            r_hit_valid <= r_vbits[i_claim.src];
        end
        if (done && wr_en) begin
            mem[r_claim.src] <= n_ent;
        end
        if (done) begin
            r_acc <= n_acc;
            r_st  <= n_st;
            r_chg <= n_chg;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_acc;
    assign o_status        = r_st;
    assign o_state_changed = r_chg;
endmodule

@@ tb/sv/tb_psarw_checker.sv @@
// Checker: predicts each claim verdict from the channel beats and compares results.
module tb_psarw_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_version,
    input  logic [3:0]  i_source_index,
    input  logic [63:0] i_boot_epoch_value,
    input  logic [63:0] i_boot_tail,
    input  logic [63:0] i_seq_number,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_accepted,
    input  logic [2:0]  i_status,
    input  logic        i_state_changed,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       acc;
        logic [2:0] st;
        logic       chg;
    } t_verdict;

    logic [7:0]                  guard_ver;
    logic                        ent_valid [psarw_pkg::SOURCES];
    logic [63:0]                 ent_epoch [psarw_pkg::SOURCES];
    logic [63:0]                 ent_tail  [psarw_pkg::SOURCES];
    logic [63:0]                 ent_high  [psarw_pkg::SOURCES];
    logic [psarw_pkg::MAP_W-1:0] ent_map   [psarw_pkg::SOURCES];
    t_verdict                    verdict_q [$];

    function automatic t_verdict judge_claim(input logic [7:0] ver, input logic [3:0] src,
                                             input logic [63:0] ep, input logic [63:0] tl,
                                             input logic [63:0] sq);
        logic [63:0]                 hi;
        logic [psarw_pkg::MAP_W-1:0] mp;
        logic [63:0]                 k;
        t_verdict                    v;
        v = '{1'b0, psarw_pkg::ST_OK, 1'b0};
        if (ver != guard_ver) return '{1'b1, psarw_pkg::ST_UNCHECKED, 1'b0};
        if (ep == 64'd0) return '{1'b0, psarw_pkg::ST_BAD_EPOCH, 1'b0};
        if (!ent_valid[src] || ent_epoch[src] != ep || ent_tail[src] != tl) begin
            if (ent_valid[src] && ep <= ent_epoch[src])
                return '{1'b0, psarw_pkg::ST_STALE, 1'b0};
            ent_valid[src] = 1'b1;
            ent_epoch[src] = ep;
            ent_tail[src]  = tl;
            ent_high[src]  = sq;
            ent_map[src]   = psarw_pkg::MAP_W'(1);
            return '{1'b1, psarw_pkg::ST_OK, 1'b1};
        end
        hi = ent_high[src];
        mp = ent_map[src];
        if (sq == 64'd0) return '{1'b0, psarw_pkg::ST_FLOOR, 1'b0};
        if (sq <= hi) begin
            k = hi - sq;
            if (k <= psarw_pkg::WINDOW && mp[k[5:0]]) return '{1'b0, psarw_pkg::ST_REPLAY, 1'b0};
        end
        if (hi > psarw_pkg::WINDOW && sq <= hi - psarw_pkg::WINDOW)
            return '{1'b0, psarw_pkg::ST_WINDOW, 1'b0};
        if (sq > hi) begin
            k = sq - hi;
            mp = (k > psarw_pkg::WINDOW) ? '0 : (mp << k[5:0]);
            mp[0] = 1'b1;
            hi = sq;
            v.chg = 1'b1;
        end else begin
            k = hi - sq;
            mp[k[5:0]] = 1'b1;
        end
        if (hi > psarw_pkg::WINDOW) mp[psarw_pkg::WINDOW] = 1'b0;
        ent_high[src] = hi;
        ent_map[src]  = mp;
        v.acc = 1'b1;
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict got;
        if (!i_rst_n) begin
            guard_ver = 8'd3;
            for (int i = 0; i < psarw_pkg::SOURCES; i++) ent_valid[i] = 1'b0;
            verdict_q.delete();
        end else begin
            if (i_cfg_we) guard_ver = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                got = '{i_accepted, i_status, i_state_changed};
                o_results <= o_results + 1;
                if (verdict_q.size() == 0) begin
                    $display("%0t: result beat with no claim pending: %b/%0d/%b", $time,
                             got.acc, got.st, got.chg);
                    o_errors <= o_errors + 1;
                end else begin
                    want = verdict_q.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch exp acc=%b st=%0d chg=%b",
                                 $time, want.acc, want.st, want.chg);
                        $display("%0t:          act acc=%b st=%0d chg=%b",
                                 $time, got.acc, got.st, got.chg);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                verdict_q.push_back(judge_claim(i_version, i_source_index, i_boot_epoch_value,
                                                i_boot_tail, i_seq_number));
        end
    end

    initial begin
        o_errors  = 0;
        o_results = 0;
    end
    assign o_pending = verdict_q.size();
endmodule

@@ tb/sv/tb_per_source_anti_replay_window_unit.sv @@
// Testbench top: claim stimulus, receiver stalls and verdict for the anti-replay unit.
module tb_per_source_anti_replay_window_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0, rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_data = '0;
    logic        in_valid = 1'b0, in_ready;
    logic [7:0]  version = '0;
    logic [3:0]  src_idx = '0;
    logic [63:0] epoch = '0, tail = '0, seq = '0;
    logic        out_valid, out_ready = 1'b0;
    logic        accepted, state_changed;
    logic [2:0]  status;
    int          errors, pending, results;
    logic [7:0]  guard = 8'd3;
    int          burst_left = 0;
    bit          stall_mode = 0;
    logic [63:0] src_epoch [16];
    logic [63:0] src_tail  [16];
    logic [63:0] src_seq   [16];

    per_source_anti_replay_window_unit dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_version(version),
        .i_source_index(src_idx), .i_boot_epoch_value(epoch), .i_boot_tail(tail),
        .i_seq_number(seq), .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_accepted(accepted), .o_status(status), .o_state_changed(state_changed)
    );

    tb_psarw_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_version(version),
        .i_source_index(src_idx), .i_boot_epoch_value(epoch), .i_boot_tail(tail),
        .i_seq_number(seq), .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_accepted(accepted), .i_status(status), .i_state_changed(state_changed),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // receiver stall pattern: alternating open stretches and random stalls
    always @(negedge clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
        out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    task automatic send_claim(input logic [7:0] v, input logic [3:0] s, input logic [63:0] e,
                              input logic [63:0] t, input logic [63:0] q);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        version  <= v;
        src_idx  <= s;
        epoch    <= e;
        tail     <= t;
        seq      <= q;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (burst_left == 0) in_valid <= 1'b0;
    endtask

    task automatic drain_then_write(input logic [7:0] v);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (6) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        guard = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_claim();
        logic [3:0]  s;
        logic [63:0] q;
        int          r;
        s = 4'($urandom);
        r = $urandom_range(0, 99);
        if (r < 4) begin
            send_claim(8'($urandom), s, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom});
        end else if (r < 8) begin
            send_claim(guard, s, 64'd0, {$urandom, $urandom}, 64'($urandom_range(0, 9)));
        end else if (r < 14) begin
            // new boot, sometimes older or same epoch
            src_epoch[s] = src_epoch[s] + 64'($urandom_range(0, 3)) - 64'd1;
            if ($urandom_range(0, 3) == 0) src_epoch[s] = {$urandom, $urandom};
            if (src_epoch[s] == 0) src_epoch[s] = 1;
            if ($urandom_range(0, 1)) src_tail[s] = {$urandom, $urandom};
            src_seq[s] = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
                                                     : 64'($urandom_range(0, 40));
            send_claim(guard, s, src_epoch[s], src_tail[s], src_seq[s]);
        end else begin
            r = $urandom_range(0, 9);
            if (r < 5) q = src_seq[s] + 64'($urandom_range(0, 40)) - 64'd36;
            else if (r < 9) q = src_seq[s] + 64'($urandom_range(1, 4));
            else q = src_seq[s] + 64'($urandom_range(30, 80));
            if (q > src_seq[s] && q - src_seq[s] < 100) src_seq[s] = q;
            if ($urandom_range(0, 40) == 0) q = 0;
            send_claim(guard, s, src_epoch[s], src_tail[s], q);
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++) begin
            src_epoch[i] = 64'd5;
            src_tail[i]  = {$urandom, $urandom};
            src_seq[i]   = '0;
        end
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed: unchecked, bad epoch, adoption, floor, replay, window, stale
        send_claim(8'hFF, 4'hF, '1, '1, '1);
        send_claim(8'd3, 4'd0, 64'd0, 64'd0, 64'd0);
        send_claim(8'd3, 4'd0, 64'd10, 64'hA, 64'd0);
        send_claim(8'd3, 4'd0, 64'd10, 64'hA, 64'd0);
        send_claim(8'd3, 4'd0, 64'd10, 64'hA, 64'd1);
        send_claim(8'd3, 4'd0, 64'd10, 64'hA, 64'd1);
        send_claim(8'd3, 4'd0, 64'd10, 64'hA, 64'd40);
        send_claim(8'd3, 4'd0, 64'd10, 64'hA, 64'd8);
        send_claim(8'd3, 4'd0, 64'd10, 64'hA, 64'd9);
        send_claim(8'd3, 4'd0, 64'd10, 64'hA, 64'd20);
        send_claim(8'd3, 4'd0, 64'd10, 64'hA, 64'd20);
        send_claim(8'd3, 4'd0, 64'd10, 64'hB, 64'd3);
        send_claim(8'd3, 4'd0, 64'd9, 64'hB, 64'd3);
        send_claim(8'd3, 4'd0, 64'd11, 64'hB, 64'd3);
        send_claim(8'd3, 4'd0, 64'd11, 64'hB, '1);
        send_claim(8'd3, 4'd0, 64'd11, 64'hB, 64'h7FFF_FFFF_FFFF_FFFF);
        send_claim(8'd3, 4'd0, '1, '1, '1);
        send_claim(8'd3, 4'd0, '1, '1, 64'd1);
        send_claim(8'd3, 4'd1, 64'd1, '0, '1);
        send_claim(8'd0, 4'd2, '1, '1, '1);
        drain_then_write(8'd0);
        send_claim(8'd0, 4'd2, 64'd1, '0, 64'd5);
        send_claim(8'd3, 4'd2, 64'd1, '0, 64'd5);
        drain_then_write(8'd255);
        send_claim(8'd255, 4'd2, 64'd1, '0, 64'd5);
        drain_then_write(8'd3);
        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < 460; n++) random_claim();
            if (ph == 0) drain_then_write(8'd0);
            if (ph == 1) drain_then_write(8'd255);
            if (ph == 2) drain_then_write(8'($urandom));
        end
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        $display("Ran %0d claim results across four guarded versions, with stalls and gaps.",
                 results);
        if (errors == 0)
            $display("per_source_anti_replay_window_unit verification clean");
        else
            $display("per_source_anti_replay_window_unit verification failed");
        $finish;
    end

    initial begin
        #200000;
        $display("per_source_anti_replay_window_unit verification failed");
        $finish;
    end
endmodule
